[rtl/pce_pkg.sv]
package pce_pkg;

    localparam int POSITION_BITS_DEF = 24;
    localparam int FRAC_BITS         = 24;
    localparam int ACC_W             = 48;
    localparam int CHUNK_W           = 24;
    localparam int VALUE_W           = 32;
    localparam int W_SEGS            = 10;
    localparam int H_SEGS            = 14;
    localparam int SEG_W             = 4;

    localparam logic [0:0] REG_BODY_LENGTH    = 1'b0;
    localparam logic [0:0] REG_PROFILE_SELECT = 1'b1;

    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;

    localparam longint Q = 64'sd16777216;

    localparam longint W_BREAK [W_SEGS] = '{
        0,
        (5 * Q + 1000 / 2) / 1000,
        (1 * Q + 100 / 2) / 100,
        (5 * Q + 100 / 2) / 100,
        (1 * Q + 10 / 2) / 10,
        (2 * Q + 10 / 2) / 10,
        (4 * Q + 10 / 2) / 10,
        (6 * Q + 10 / 2) / 10,
        (8 * Q + 10 / 2) / 10,
        (95 * Q + 100 / 2) / 100
    };

    localparam longint H_BREAK [H_SEGS] = '{
        0,
        (1 * Q + 100 / 2) / 100,
        (5 * Q + 100 / 2) / 100,
        (1 * Q + 10 / 2) / 10,
        (3 * Q + 10 / 2) / 10,
        (5 * Q + 10 / 2) / 10,
        (7 * Q + 10 / 2) / 10,
        (8 * Q + 10 / 2) / 10,
        (85 * Q + 100 / 2) / 100,
        (87 * Q + 100 / 2) / 100,
        (9 * Q + 10 / 2) / 10,
        (993 * Q + 1000 / 2) / 1000,
        (996 * Q + 1000 / 2) / 1000,
        (998 * Q + 1000 / 2) / 1000
    };

    // per segment: c0, c1, c2, c3 in Q24.24
    localparam longint W_COEF [W_SEGS][4] = '{
        '{(15713 * Q + 10000000 / 2) / 10000000,
          (26439 * Q + 10000 / 2) / 10000,
          0,
          -(15410 * Q)},
        '{(12865 * Q + 1000000 / 2) / 1000000,
          (14882 * Q + 10000 / 2) / 10000,
          -((23115 * Q + 100 / 2) / 100),
          15598 * Q},
        '{(16476 * Q + 1000000 / 2) / 1000000,
          (34647 * Q + 100000 / 2) / 100000,
          (28156 * Q + 10000 / 2) / 10000,
          -((39328 * Q + 1000 / 2) / 1000)},
        '{(32323 * Q + 1000000 / 2) / 1000000,
          (38294 * Q + 100000 / 2) / 100000,
          -((19038 * Q + 10000 / 2) / 10000),
          (7411 * Q + 10000 / 2) / 10000},
        '{(46803 * Q + 1000000 / 2) / 1000000,
          (19812 * Q + 100000 / 2) / 100000,
          -((17926 * Q + 10000 / 2) / 10000),
          (54876 * Q + 10000 / 2) / 10000},
        '{(54176 * Q + 1000000 / 2) / 1000000,
          (42136 * Q + 10000000 / 2) / 10000000,
          -((14638 * Q + 100000 / 2) / 100000),
          (77447 * Q + 1000000 / 2) / 1000000},
        '{(49783 * Q + 1000000 / 2) / 1000000,
          -((45043 * Q + 1000000 / 2) / 1000000),
          -((99907 * Q + 1000000 / 2) / 1000000),
          -((12599 * Q + 100000 / 2) / 100000)},
        '{(3577 * Q + 100000 / 2) / 100000,
          -((10012 * Q + 100000 / 2) / 100000),
          -((1755 * Q + 10000 / 2) / 10000),
          (62019 * Q + 100000 / 2) / 100000},
        '{(13687 * Q + 1000000 / 2) / 1000000,
          -((959 * Q + 10000 / 2) / 10000),
          (19662 * Q + 100000 / 2) / 100000,
          (82341 * Q + 100000 / 2) / 100000},
        '{(65049 * Q + 10000000 / 2) / 10000000,
          (18665 * Q + 1000000 / 2) / 1000000,
          (56715 * Q + 100000 / 2) / 100000,
          -((3781 * Q + 1000 / 2) / 1000)}
    };

    localparam longint H_COEF [H_SEGS][4] = '{
        '{(11746 * Q + 10000000 / 2) / 10000000,
          (1345 * Q + 1000 / 2) / 1000,
          0,
          -((57862 * Q + 100 / 2) / 100)},
        '{(14046 * Q + 1000000 / 2) / 1000000,
          (11715 * Q + 10000 / 2) / 10000,
          -((17359 * Q + 1000 / 2) / 1000),
          (1286 * Q + 10 / 2) / 10},
        '{(41361 * Q + 1000000 / 2) / 1000000,
          (40004 * Q + 100000 / 2) / 100000,
          -((19268 * Q + 10000 / 2) / 10000),
          (97029 * Q + 10000 / 2) / 10000},
        '{(57759 * Q + 1000000 / 2) / 1000000,
          (28013 * Q + 100000 / 2) / 100000,
          -((47141 * Q + 100000 / 2) / 100000),
          -((8102 * Q + 100000 / 2) / 100000)},
        '{(94281 * Q + 1000000 / 2) / 1000000,
          (81843 * Q + 1000000 / 2) / 1000000,
          -((52002 * Q + 100000 / 2) / 100000),
          -((76511 * Q + 100000 / 2) / 100000)},
        '{(83728 * Q + 1000000 / 2) / 1000000,
          -((21798 * Q + 100000 / 2) / 100000),
          -((97909 * Q + 100000 / 2) / 100000),
          (39699 * Q + 10000 / 2) / 10000},
        '{(32727 * Q + 1000000 / 2) / 1000000,
          -((13323 * Q + 100000 / 2) / 100000),
          (14028 * Q + 10000 / 2) / 10000,
          (25693 * Q + 10000 / 2) / 10000},
        '{(36002 * Q + 1000000 / 2) / 1000000,
          (22441 * Q + 100000 / 2) / 100000,
          (21736 * Q + 10000 / 2) / 10000,
          -((13194 * Q + 1000 / 2) / 1000)},
        '{(51007 * Q + 1000000 / 2) / 1000000,
          (34282 * Q + 100000 / 2) / 100000,
          (19446 * Q + 100000 / 2) / 100000,
          (16642 * Q + 1000 / 2) / 1000},
        '{(58075 * Q + 1000000 / 2) / 1000000,
          (37057 * Q + 100000 / 2) / 100000,
          (1193 * Q + 1000 / 2) / 1000,
          -((17944 * Q + 1000 / 2) / 1000)},
        '{(69781 * Q + 1000000 / 2) / 1000000,
          (3937 * Q + 10000 / 2) / 10000,
          -((42196 * Q + 100000 / 2) / 100000),
          -((29388 * Q + 1000 / 2) / 1000)},
        '{(79107 * Q + 1000000 / 2) / 1000000,
          -((44731 * Q + 100000 / 2) / 100000),
          -((86211 * Q + 10000 / 2) / 10000),
          -(182830 * Q)},
        '{(72751 * Q + 1000000 / 2) / 1000000,
          -((54355 * Q + 10000 / 2) / 10000),
          -((16541 * Q + 10 / 2) / 10),
          -(291210 * Q)},
        '{(52934 * Q + 1000000 / 2) / 1000000,
          -((15546 * Q + 1000 / 2) / 1000),
          -((34014 * Q + 10 / 2) / 10),
          566890 * Q}
    };

    typedef logic signed [ACC_W-1:0] t_acc;
    typedef logic [FRAC_BITS-1:0]    t_frac;
    typedef logic [SEG_W-1:0]        t_seg;

    function automatic t_acc coef_rom(input logic sel, input t_seg seg, input logic [1:0] k);
        longint v;
        v = 0;
        if (sel) begin
            v = H_COEF[seg][k];
        end else if (seg < SEG_W'(W_SEGS)) begin
            v = W_COEF[seg][k];
        end
        return ACC_W'(v);
    endfunction

    function automatic t_frac brk_rom(input logic sel, input t_seg seg);
        longint v;
        v = 0;
        if (sel) begin
            v = H_BREAK[seg];
        end else if (seg < SEG_W'(W_SEGS)) begin
            v = W_BREAK[seg];
        end
        return FRAC_BITS'(v);
    endfunction

endpackage

[rtl/piecewise_cubic_profile_eval.sv]
// Piecewise cubic profile evaluator: one position s (Q8.16) in, one signed Q16.16 value out.
// Positions outside the open interval (0, L) give 0 and skip the datapath. Inside, the
// restoring divider forms s/L one quotient bit per cycle, then the segment search and
// offset follow, then four passes through one shared 25-bit by max(24, POSITION_BITS)-bit
// multiplier (each product taken in two halves of the accumulator, summed and rounded),
// three for the Horner steps and one for the scaling by L, and the result is then loaded
// into the output register. The input stalls while an item is at work; a finished result
// waits in the output register, so the next item may already be taken.
// body_length and profile_select are to be written only while the unit is idle.
module piecewise_cubic_profile_eval #(
    parameter int POSITION_BITS = pce_pkg::POSITION_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [POSITION_BITS-1:0]             i_position,
    input  logic                                 i_last_point,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [pce_pkg::VALUE_W-1:0]   o_profile_value,
    output logic                                 o_end_of_run,
    output logic                                 o_saturated,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [0:0]                           i_cfg_index,
    input  logic [POSITION_BITS-1:0]             i_cfg_data
);
    import pce_pkg::*;

    localparam int MW    = (POSITION_BITS > FRAC_BITS) ? POSITION_BITS : FRAC_BITS;
    localparam int PROD_W = CHUNK_W + 1 + MW + 1;
    localparam int SUMW  = ACC_W + MW + 1;
    localparam int CNT_W = $clog2(FRAC_BITS);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DIV    = 4'd1;
    localparam logic [3:0] ST_SEG    = 4'd2;
    localparam logic [3:0] ST_XOFF   = 4'd3;
    localparam logic [3:0] ST_MUL_LO = 4'd4;
    localparam logic [3:0] ST_MUL_HI = 4'd5;
    localparam logic [3:0] ST_ACCUM  = 4'd6;
    localparam logic [3:0] ST_ROUND  = 4'd7;
    localparam logic [3:0] ST_FIN    = 4'd8;

    localparam logic [1:0] STEP_FINAL = 2'd3;

    logic [3:0]                  r_state, n_state;
    logic [POSITION_BITS-1:0]    r_len;
    logic                        r_sel;
    logic [POSITION_BITS:0]      r_rem;
    t_frac                       r_quot;
    logic [CNT_W-1:0]            r_cnt;
    t_seg                        r_seg;
    t_frac                       r_x;
    t_acc                        r_acc;
    logic [1:0]                  r_step;
    logic signed [PROD_W-1:0]    r_prod;
    logic signed [SUMW-1:0]      r_sum;
    logic                        r_last;
    logic signed [VALUE_W-1:0]   r_res_value;
    logic                        r_res_sat;
    logic                        r_out_valid;
    logic signed [VALUE_W-1:0]   r_value;
    logic                        r_end;
    logic                        r_sat;

    logic                        in_beat;
    logic                        in_body;
    logic [POSITION_BITS:0]      rem2;
    logic [POSITION_BITS:0]      rem_diff;
    logic                        q_bit;
    t_seg                        seg_found;
    logic signed [CHUNK_W:0]     a_op;
    logic signed [MW:0]          b_op;
    logic signed [SUMW-1:0]      rounded;
    logic                        out_load;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_beat     = i_in_valid && !o_in_stall;
    assign in_body     = (i_position != '0) && (i_position < r_len);
    assign out_load    = (r_state == ST_FIN) && (!r_out_valid || !i_out_stall);

    // restoring divider step
    assign rem2     = {r_rem[POSITION_BITS-1:0], 1'b0};
    assign rem_diff = rem2 - {1'b0, r_len};
    assign q_bit    = (rem2 >= {1'b0, r_len});

    always_comb begin
        seg_found = '0;
        for (int k = 1; k < H_SEGS; k++) begin
            if ((r_sel || k < W_SEGS) && r_quot >= brk_rom(r_sel, SEG_W'(k))) begin
                seg_found = SEG_W'(k);
            end
        end
    end

    // shared multiplier operands: low half unsigned, high half signed
    always_comb begin
        if (r_state == ST_MUL_LO) begin
            a_op = {1'b0, r_acc[CHUNK_W-1:0]};
        end else begin
            a_op = {r_acc[ACC_W-1], r_acc[ACC_W-1:CHUNK_W]};
        end
        if (r_step == STEP_FINAL) begin
            b_op = {1'b0, MW'(r_len)};
        end else begin
            b_op = {1'b0, MW'(r_x)};
        end
    end

    assign rounded = (r_sum + (SUMW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_beat) begin
                    n_state = in_body ? ST_DIV : ST_FIN;
                end
            end
            ST_DIV: begin
                if (r_cnt == CNT_W'(FRAC_BITS - 1)) begin
                    n_state = ST_SEG;
                end
            end
            ST_SEG:    n_state = ST_XOFF;
            ST_XOFF:   n_state = ST_MUL_LO;
            ST_MUL_LO: n_state = ST_MUL_HI;
            ST_MUL_HI: n_state = ST_ACCUM;
            ST_ACCUM:  n_state = ST_ROUND;
            ST_ROUND:  n_state = (r_step == STEP_FINAL) ? ST_FIN : ST_MUL_LO;
            ST_FIN: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_len       <= POSITION_BITS'(65536);
            r_sel       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    REG_BODY_LENGTH:    r_len <= i_cfg_data;
                    REG_PROFILE_SELECT: r_sel <= i_cfg_data[0];
                    default:            r_sel <= r_sel;
                endcase
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_rem       <= {1'b0, i_position};
                r_cnt       <= '0;
                r_step      <= '0;
                r_last      <= i_last_point;
                r_res_value <= '0;
                r_res_sat   <= 1'b0;
            end
            ST_DIV: begin
                r_rem  <= q_bit ? rem_diff : rem2;
                r_quot <= {r_quot[FRAC_BITS-2:0], q_bit};
                r_cnt  <= r_cnt + CNT_W'(1);
            end
            ST_SEG: begin
                r_seg <= seg_found;
            end
            ST_XOFF: begin
                r_x   <= r_quot - brk_rom(r_sel, r_seg);
                r_acc <= coef_rom(r_sel, r_seg, 2'd3);
            end
            ST_MUL_LO: begin
                r_prod <= a_op * b_op;
            end
            ST_MUL_HI: begin
                r_prod <= a_op * b_op;
                r_sum  <= SUMW'(r_prod);
            end
            ST_ACCUM: begin
                r_sum <= r_sum + (SUMW'(r_prod) <<< CHUNK_W);
            end
            ST_ROUND: begin
                if (r_step == STEP_FINAL) begin
                    // clip to the Q16.16 range
                    if (rounded > SUMW'(VAL_MAX)) begin
                        r_res_value <= VAL_MAX;
                        r_res_sat   <= 1'b1;
                    end else if (rounded < SUMW'(VAL_MIN)) begin
                        r_res_value <= VAL_MIN;
                        r_res_sat   <= 1'b1;
                    end else begin
                        r_res_value <= VALUE_W'(rounded);
                    end
                end else begin
                    r_acc  <= ACC_W'(rounded) + coef_rom(r_sel, r_seg, 2'(2'd2 - r_step));
                    r_step <= r_step + 2'd1;
                end
            end
            default: begin
                r_step <= r_step;
            end
        endcase
        if (out_load) begin
            r_value <= r_res_value;
            r_end   <= r_last;
            r_sat   <= r_res_sat;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_profile_value = r_value;
    assign o_end_of_run    = r_end;
    assign o_saturated     = r_sat;

`ifndef SYNTH
    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == ST_FIN)
        else $error("result appeared without a finished item");

    a_outside_skips: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat && i_position == '0 |=> r_state == ST_FIN)
        else $error("position zero did not bypass the datapath");

    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_saturated |-> o_profile_value == VAL_MAX || o_profile_value == VAL_MIN)
        else $error("saturated flag without a clipped value");

    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SEG |-> $past(r_state) == ST_DIV && $past(r_cnt) == CNT_W'(FRAC_BITS - 1))
        else $error("segment search entered before the quotient completed");
`endif

endmodule
